// ----- rtl/fcull_pkg.sv -----
`timescale 1ns / 1ps
// Package for the frustum box cull core: widths, types, register codes
// and the coefficient unpacking helper. Depends on nothing.
package fcull_pkg;

  localparam int POS_BITS   = 24;
  localparam int COEF_BITS  = 16;
  localparam int ROW_BITS   = 64;
  localparam int NUM_ROWS   = 4;
  localparam int NUM_AXES   = 3;
  localparam int NUM_PLANES = 6;
  localparam int EDGE_SHIFT = 4;   // cube edge of 16 units
  localparam int CFG_IDX_W  = 2;

  // product of one coefficient and one coordinate
  localparam int PROD_W  = POS_BITS + COEF_BITS;
  // three products plus the constant term
  localparam int DOT_W   = PROD_W + 2;
  // row w plus or minus another row, plus the corner offset term
  localparam int DIST_W  = DOT_W + 3;
  localparam int PCOEF_W = COEF_BITS + 1;

  typedef logic        [ROW_BITS-1:0]  row_t;
  typedef logic signed [POS_BITS-1:0]  pos_t;
  typedef logic signed [COEF_BITS-1:0] coef_t;
  typedef logic signed [PCOEF_W-1:0]   pcoef_t;
  typedef logic signed [PROD_W-1:0]    prod_t;
  typedef logic signed [DOT_W-1:0]     dot_t;
  typedef logic signed [DIST_W-1:0]    dist_t;

  // configuration register codes, also the row numbers
  typedef enum logic [CFG_IDX_W-1:0] {
    ROW_X = 2'd0,
    ROW_Y = 2'd1,
    ROW_Z = 2'd2,
    ROW_W = 2'd3
  } row_sel_t;

  // column 3 holds the constant term
  localparam int COL_D = 3;

  function automatic coef_t coef_of(input row_t row, input int col);
    coef_of = coef_t'(row[col*COEF_BITS +: COEF_BITS]);
  endfunction

endpackage

// ----- rtl/fcull_mul.sv -----
`timescale 1ns / 1ps
// Product stage: multiplies every matrix coefficient of columns 0 to 2 by
// its coordinate and registers the twelve products. Uses fcull_pkg.
module fcull_mul (
  input  logic           clk,
  input  logic           load,
  input  fcull_pkg::row_t rows [fcull_pkg::NUM_ROWS],
  input  fcull_pkg::pos_t org  [fcull_pkg::NUM_AXES],
  output fcull_pkg::prod_t prod [fcull_pkg::NUM_ROWS][fcull_pkg::NUM_AXES]
);
  import fcull_pkg::*;

  // advance products when the next stage can take them
  always_ff @(posedge clk) begin
    if (load) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        for (int c = 0; c < NUM_AXES; c++) begin
          prod[r][c] <= prod_t'(coef_of(rows[r], c)) * prod_t'(org[c]);
        end
      end
    end
  end

endmodule

// ----- rtl/fcull_dot.sv -----
`timescale 1ns / 1ps
// Row stage: sums the three products of each matrix row with the row's
// constant term, giving the row value at the chunk origin. Uses fcull_pkg.
module fcull_dot (
  input  logic            clk,
  input  logic            load,
  input  fcull_pkg::row_t  rows [fcull_pkg::NUM_ROWS],
  input  fcull_pkg::prod_t prod [fcull_pkg::NUM_ROWS][fcull_pkg::NUM_AXES],
  output fcull_pkg::dot_t  dot  [fcull_pkg::NUM_ROWS]
);
  import fcull_pkg::*;

  // hold row sums until the plane stage takes them
  always_ff @(posedge clk) begin
    if (load) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        dot[r] <= dot_t'(prod[r][0]) + dot_t'(prod[r][1]) + dot_t'(prod[r][2])
                + dot_t'(coef_of(rows[r], COL_D));
      end
    end
  end

endmodule

// ----- rtl/fcull_plane.sv -----
`timescale 1ns / 1ps
// Plane stage: forms the six clip planes and tests the farthest corner of
// the cube along each plane normal; flags planes with every corner behind.
// Uses fcull_pkg.
module fcull_plane (
  input  logic           clk,
  input  logic           load,
  input  fcull_pkg::row_t rows [fcull_pkg::NUM_ROWS],
  input  fcull_pkg::dot_t dot  [fcull_pkg::NUM_ROWS],
  output logic [fcull_pkg::NUM_PLANES-1:0] outside
);
  import fcull_pkg::*;

  dist_t bonus     [NUM_PLANES];
  dist_t best_dist [NUM_PLANES];

  // Offset of the most positive corner: add one edge along every axis whose
  // plane coefficient is positive. Depends on configuration only.
  always_comb begin
    pcoef_t pc;
    for (int p = 0; p < NUM_PLANES; p++) begin
      bonus[p] = '0;
      for (int c = 0; c < NUM_AXES; c++) begin
        if (p[0]) begin
          pc = pcoef_t'(coef_of(rows[ROW_W], c)) - pcoef_t'(coef_of(rows[p >> 1], c));
        end else begin
          pc = pcoef_t'(coef_of(rows[ROW_W], c)) + pcoef_t'(coef_of(rows[p >> 1], c));
        end
        if (!pc[PCOEF_W-1]) begin
          bonus[p] = bonus[p] + (dist_t'(pc) <<< EDGE_SHIFT);
        end
      end
    end
  end

  // plane distance at the most positive corner
  always_comb begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      if (p[0]) begin
        best_dist[p] = dist_t'(dot[ROW_W]) - dist_t'(dot[p >> 1]) + bonus[p];
      end else begin
        best_dist[p] = dist_t'(dot[ROW_W]) + dist_t'(dot[p >> 1]) + bonus[p];
      end
    end
  end

  // hold one flag per plane: even the best corner lies strictly behind it
  always_ff @(posedge clk) begin
    if (load) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        outside[p] <= best_dist[p][DIST_W-1];
      end
    end
  end

endmodule

// ----- rtl/frustum_box_cull_core.sv -----
`timescale 1ns / 1ps
// Top level of the frustum box cull core: configuration registers, stage
// valid bits and flow control. Uses fcull_pkg, fcull_mul, fcull_dot, fcull_plane.
//
// Usage:
//   Load the four projection-view matrix rows through cfg_wr_en, cfg_index
//   and cfg_data while the core is idle; indexes 0 to 3 select rows x, y, z
//   and w. Then send chunk origins on the in channel (in_valid, in_ready,
//   chunk_x, chunk_y, chunk_z). Each word yields one word on the out channel
//   (out_valid, out_ready, visible): 1 if the 16-unit cube may lie inside the
//   frustum, 0 if all of it lies behind one of the six clip planes.
//   Pipeline: five register stages (input, products, row sums, plane flags,
//   output). Throughput: one word per cycle while out_ready stays high;
//   each stage holds one word and the twelve products are formed in
//   parallel in a single stage.
//   Reset (rst, synchronous): clears all valid bits and the matrix rows.
//   Receiver stall: a full stage holds its word while the next one cannot load;
//   bubbles close up, and in_ready drops only when every stage is full.
module frustum_box_cull_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  fcull_pkg::pos_t                chunk_x,
  input  fcull_pkg::pos_t                chunk_y,
  input  fcull_pkg::pos_t                chunk_z,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           visible,
  input  logic                           cfg_wr_en,
  input  logic [fcull_pkg::CFG_IDX_W-1:0] cfg_index,
  input  fcull_pkg::row_t                cfg_data
);
  import fcull_pkg::*;

  row_t  rows [NUM_ROWS];
  pos_t  org  [NUM_AXES];
  prod_t prod [NUM_ROWS][NUM_AXES];
  dot_t  dot  [NUM_ROWS];
  logic [NUM_PLANES-1:0] outside;

  logic org_valid, prod_valid, dot_valid, flag_valid;
  logic load_org, load_prod, load_dot, load_flag, load_out;

  // write matrix rows
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        rows[r] <= '0;
      end
    end else if (cfg_wr_en) begin
      unique case (row_sel_t'(cfg_index))
        ROW_X: rows[ROW_X] <= cfg_data;
        ROW_Y: rows[ROW_Y] <= cfg_data;
        ROW_Z: rows[ROW_Z] <= cfg_data;
        ROW_W: rows[ROW_W] <= cfg_data;
        default: ;
      endcase
    end
  end

  // a stage loads when it is empty or its word moves on this cycle
  assign load_out  = !out_valid  || out_ready;
  assign load_flag = !flag_valid || load_out;
  assign load_dot  = !dot_valid  || load_flag;
  assign load_prod = !prod_valid || load_dot;
  assign load_org  = !org_valid  || load_prod;
  assign in_ready  = load_org;

  // advance valid bits with their words
  always_ff @(posedge clk) begin
    if (rst) begin
      org_valid  <= 1'b0;
      prod_valid <= 1'b0;
      dot_valid  <= 1'b0;
      flag_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (load_org)  org_valid  <= in_valid;
      if (load_prod) prod_valid <= org_valid;
      if (load_dot)  dot_valid  <= prod_valid;
      if (load_flag) flag_valid <= dot_valid;
      if (load_out)  out_valid  <= flag_valid;
    end
  end

  // capture the chunk origin
  always_ff @(posedge clk) begin
    if (load_org) begin
      org[0] <= chunk_x;
      org[1] <= chunk_y;
      org[2] <= chunk_z;
    end
  end

  fcull_mul u_mul (
    .clk  (clk),
    .load (load_prod),
    .rows (rows),
    .org  (org),
    .prod (prod)
  );

  fcull_dot u_dot (
    .clk  (clk),
    .load (load_dot),
    .rows (rows),
    .prod (prod),
    .dot  (dot)
  );

  fcull_plane u_plane (
    .clk     (clk),
    .load    (load_flag),
    .rows    (rows),
    .dot     (dot),
    .outside (outside)
  );

  // drop the chunk if any plane has it wholly behind
  always_ff @(posedge clk) begin
    if (load_out) begin
      visible <= ~|outside;
    end
  end

endmodule

// ----- rtl/fcull_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for frustum_box_cull_core, bound to the top level.
// Depends only on the handshake ports and the visible flag of the top level.
module fcull_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic visible
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set right after reset");

  // with the output free to move, every stage can move, so input is taken
  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("in_ready low while output stage can drain");

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped during stall");

  // a stalled result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(visible))
    else $error("visible changed during stall");

endmodule

bind frustum_box_cull_core fcull_checker u_fcull_checker (.*);
